/* rtl/slpp_pkg.sv */
// types, constants and layout tables shared by the slp v1 field parser
package slpp_pkg;

    localparam int unsigned STEP_W     = 6;
    localparam int unsigned ADV_PASSES = 4;
    localparam int unsigned TUSER_W    = 11;

    localparam logic [STEP_W-1:0] BODY_BASE  = 6'd8;
    localparam logic [STEP_W-1:0] BODY_END   = 6'd18;
    localparam logic [STEP_W-1:0] AUTH_BASE  = 6'd48;
    localparam logic [STEP_W-1:0] AUTH_END   = 6'd53;
    localparam logic [7:0]        MASK_U     = 8'h20;
    localparam logic [7:0]        MASK_A     = 8'h10;

    typedef enum logic [3:0] {
        OP_END,
        OP_FIX,
        OP_LEN,
        OP_BODY,
        OP_CNT,
        OP_AUTH,
        OP_LOOP,
        OP_RET,
        OP_UNK
    } op_t;

    typedef enum logic [4:0] {
        KIND_VERSION,
        KIND_FUNCTION,
        KIND_LENGTH,
        KIND_FLAGS,
        KIND_DIALECT,
        KIND_LANGUAGE,
        KIND_ENCODING,
        KIND_XID,
        KIND_ERROR,
        KIND_COUNT,
        KIND_LIFETIME,
        KIND_LIST_LEN,
        KIND_LIST_BODY,
        KIND_AUTH_TIME,
        KIND_AUTH_DESC,
        KIND_AUTH_LEN,
        KIND_AUTH_BODY,
        KIND_PAYLOAD,
        KIND_TRAILING
    } kind_t;

    typedef enum logic [2:0] {
        LIST_NONE,
        LIST_PREV_RESP,
        LIST_PREDICATE,
        LIST_URL,
        LIST_ATTR,
        LIST_SCOPES,
        LIST_NAMING_AUTH,
        LIST_SRV_TYPES
    } list_t;

    typedef enum logic [3:0] {
        FN_UNKNOWN,
        FN_SRV_RQST,
        FN_SRV_RPLY,
        FN_SRV_REG,
        FN_SRV_DEREG,
        FN_SRV_ACK,
        FN_ATTR_RQST,
        FN_ATTR_RPLY,
        FN_DA_ADVERT,
        FN_SRV_TYPE_RQST,
        FN_SRV_TYPE_RPLY
    } func_t;

    typedef struct packed {
        op_t        op;
        kind_t      kind;
        list_t      list;
        logic [3:0] len;
        logic [7:0] arg;
    } slot_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [15:0]       bytes_left;
        logic [7:0]        func;
        logic [7:0]        flags;
        logic [15:0]       items;
        logic [7:0]        len_hi;
        logic [STEP_W-1:0] auth_ret;
        logic              body_open;
    } state_t;

    localparam state_t STATE_RESET = '0;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        list_t      list;
        logic       fld_first;
        logic       fld_last;
        logic       trunc;
        logic       eom;
    } res_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              len_zero;
        logic              items_one;
        logic [7:0]        flags;
        logic [7:0]        func;
        logic [STEP_W-1:0] auth_ret;
    } adv_req_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        op_t               op;
        logic              loop_taken;
        logic [STEP_W-1:0] auth_ret;
    } adv_res_t;

    function automatic slot_t mk_slot(input op_t op, input kind_t kind, input list_t list,
                                      input logic [3:0] len, input logic [7:0] arg);
        slot_t s;
        s.op   = op;
        s.kind = kind;
        s.list = list;
        s.len  = len;
        s.arg  = arg;
        return s;
    endfunction

    function automatic slot_t fx(input kind_t kind, input logic [3:0] len);
        return mk_slot(OP_FIX, kind, LIST_NONE, len, 8'd0);
    endfunction

    function automatic slot_t ln(input list_t list);
        return mk_slot(OP_LEN, KIND_LIST_LEN, list, 4'd2, 8'd0);
    endfunction

    function automatic slot_t bd(input list_t list);
        return mk_slot(OP_BODY, KIND_LIST_BODY, list, 4'd0, 8'd0);
    endfunction

    function automatic slot_t cn(input list_t list, input logic [7:0] skip);
        return mk_slot(OP_CNT, KIND_COUNT, list, 4'd2, skip);
    endfunction

    function automatic slot_t au(input logic [7:0] mask);
        return mk_slot(OP_AUTH, KIND_VERSION, LIST_NONE, 4'd0, mask);
    endfunction

    function automatic slot_t lp(input logic [7:0] target);
        return mk_slot(OP_LOOP, KIND_VERSION, LIST_NONE, 4'd0, target);
    endfunction

    function automatic slot_t en();
        return mk_slot(OP_END, KIND_TRAILING, LIST_NONE, 4'd0, 8'd0);
    endfunction

    // fixed 12-byte header
    function automatic slot_t hdr_slot(input logic [2:0] idx);
        slot_t s;
        unique case (idx)
            3'd0:    s = fx(KIND_VERSION, 4'd1);
            3'd1:    s = fx(KIND_FUNCTION, 4'd1);
            3'd2:    s = fx(KIND_LENGTH, 4'd2);
            3'd3:    s = fx(KIND_FLAGS, 4'd1);
            3'd4:    s = fx(KIND_DIALECT, 4'd1);
            3'd5:    s = fx(KIND_LANGUAGE, 4'd2);
            3'd6:    s = fx(KIND_ENCODING, 4'd2);
            default: s = fx(KIND_XID, 4'd2);
        endcase
        return s;
    endfunction

    // timestamp, descriptor, length, body, then return
    function automatic slot_t auth_slot(input logic [2:0] idx);
        slot_t s;
        unique case (idx)
            3'd0:    s = fx(KIND_AUTH_TIME, 4'd8);
            3'd1:    s = fx(KIND_AUTH_DESC, 4'd2);
            3'd2:    s = mk_slot(OP_LEN, KIND_AUTH_LEN, LIST_NONE, 4'd2, 8'd0);
            3'd3:    s = mk_slot(OP_BODY, KIND_AUTH_BODY, LIST_NONE, 4'd0, 8'd0);
            3'd4:    s = mk_slot(OP_RET, KIND_VERSION, LIST_NONE, 4'd0, 8'd0);
            default: s = en();
        endcase
        return s;
    endfunction

    function automatic slot_t body_slot(input func_t row, input logic [3:0] idx);
        slot_t s;
        s = en();
        unique case (row)
            FN_SRV_RQST:
                unique case (idx)
                    4'd0:    s = ln(LIST_PREV_RESP);
                    4'd1:    s = bd(LIST_PREV_RESP);
                    4'd2:    s = ln(LIST_PREDICATE);
                    4'd3:    s = bd(LIST_PREDICATE);
                    default: s = en();
                endcase
            FN_SRV_RPLY:
                unique case (idx)
                    4'd0:    s = fx(KIND_ERROR, 4'd2);
                    4'd1:    s = cn(LIST_URL, 8'd7);
                    4'd2:    s = fx(KIND_LIFETIME, 4'd2);
                    4'd3:    s = ln(LIST_URL);
                    4'd4:    s = bd(LIST_URL);
                    4'd5:    s = au(MASK_U);
                    4'd6:    s = lp(8'd2);
                    default: s = en();
                endcase
            FN_SRV_REG:
                unique case (idx)
                    4'd0:    s = fx(KIND_LIFETIME, 4'd2);
                    4'd1:    s = ln(LIST_URL);
                    4'd2:    s = bd(LIST_URL);
                    4'd3:    s = au(MASK_U);
                    4'd4:    s = ln(LIST_ATTR);
                    4'd5:    s = bd(LIST_ATTR);
                    4'd6:    s = au(MASK_A);
                    default: s = en();
                endcase
            FN_SRV_DEREG:
                unique case (idx)
                    4'd0:    s = ln(LIST_URL);
                    4'd1:    s = bd(LIST_URL);
                    4'd2:    s = au(MASK_U);
                    4'd3:    s = ln(LIST_ATTR);
                    4'd4:    s = bd(LIST_ATTR);
                    4'd5:    s = au(MASK_A);
                    default: s = en();
                endcase
            FN_SRV_ACK:
                unique case (idx)
                    4'd0:    s = fx(KIND_ERROR, 4'd2);
                    default: s = en();
                endcase
            FN_ATTR_RQST:
                unique case (idx)
                    4'd0:    s = ln(LIST_PREV_RESP);
                    4'd1:    s = bd(LIST_PREV_RESP);
                    4'd2:    s = ln(LIST_URL);
                    4'd3:    s = bd(LIST_URL);
                    4'd4:    s = ln(LIST_SCOPES);
                    4'd5:    s = bd(LIST_SCOPES);
                    4'd6:    s = ln(LIST_ATTR);
                    4'd7:    s = bd(LIST_ATTR);
                    default: s = en();
                endcase
            FN_ATTR_RPLY:
                unique case (idx)
                    4'd0:    s = fx(KIND_ERROR, 4'd2);
                    4'd1:    s = ln(LIST_ATTR);
                    4'd2:    s = bd(LIST_ATTR);
                    4'd3:    s = au(MASK_A);
                    default: s = en();
                endcase
            FN_DA_ADVERT:
                unique case (idx)
                    4'd0:    s = fx(KIND_ERROR, 4'd2);
                    4'd1:    s = ln(LIST_URL);
                    4'd2:    s = bd(LIST_URL);
                    4'd3:    s = ln(LIST_SCOPES);
                    4'd4:    s = bd(LIST_SCOPES);
                    default: s = en();
                endcase
            FN_SRV_TYPE_RQST:
                unique case (idx)
                    4'd0:    s = ln(LIST_PREV_RESP);
                    4'd1:    s = bd(LIST_PREV_RESP);
                    4'd2:    s = ln(LIST_NAMING_AUTH);
                    4'd3:    s = bd(LIST_NAMING_AUTH);
                    4'd4:    s = ln(LIST_SCOPES);
                    4'd5:    s = bd(LIST_SCOPES);
                    default: s = en();
                endcase
            FN_SRV_TYPE_RPLY:
                unique case (idx)
                    4'd0:    s = fx(KIND_ERROR, 4'd2);
                    4'd1:    s = cn(LIST_SRV_TYPES, 8'd6);
                    4'd2:    s = ln(LIST_SRV_TYPES);
                    4'd3:    s = bd(LIST_SRV_TYPES);
                    4'd4:    s = lp(8'd2);
                    default: s = en();
                endcase
            default:
                // unknown function: whole body is opaque payload
                if (idx == 4'd0)
                begin
                    s = mk_slot(OP_UNK, KIND_PAYLOAD, LIST_NONE, 4'd0, 8'd0);
                end
        endcase
        return s;
    endfunction

    function automatic slot_t slot_at(input logic [STEP_W-1:0] step, input logic [7:0] func);
        func_t             row;
        logic [STEP_W-1:0] rel;
        slot_t             s;
        row = (func <= {4'd0, FN_SRV_TYPE_RPLY}) ? func_t'(func[3:0]) : FN_UNKNOWN;
        if (step < BODY_BASE)
        begin
            s = hdr_slot(step[2:0]);
        end
        else if (step >= AUTH_BASE && step < AUTH_END)
        begin
            rel = step - AUTH_BASE;
            s   = auth_slot(rel[2:0]);
        end
        else if (step < BODY_END)
        begin
            rel = step - BODY_BASE;
            s   = body_slot(row, rel[3:0]);
        end
        else
        begin
            s = en();
        end
        return s;
    endfunction

endpackage

/* rtl/slpp_advance.sv */
// resolves layout steps that take no byte (empty bodies, auth insertion, loops, returns)
module slpp_advance
(
    input  slpp_pkg::adv_req_t req,
    output slpp_pkg::adv_res_t res
);

    slpp_pkg::slot_t                   cur;
    logic [slpp_pkg::STEP_W-1:0]       step;
    logic [slpp_pkg::STEP_W-1:0]       ret;
    logic                              loop_taken;
    logic                              done;

    // at most three zero-byte steps chain before a byte-taking step is reached
    always_comb
    begin
        step       = req.step;
        ret        = req.auth_ret;
        loop_taken = 1'b0;
        done       = 1'b0;
        cur        = slpp_pkg::slot_at(step, req.func);
        for (int i = 0; i < slpp_pkg::ADV_PASSES; i++)
        begin
            cur = slpp_pkg::slot_at(step, req.func);
            if (!done)
            begin
                unique case (cur.op)
                    slpp_pkg::OP_BODY:
                        if (req.len_zero)
                        begin
                            step = step + 6'd1;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    slpp_pkg::OP_AUTH:
                        if ((req.flags & cur.arg) != 8'd0)
                        begin
                            ret  = step + 6'd1;
                            step = slpp_pkg::AUTH_BASE;
                        end
                        else
                        begin
                            step = step + 6'd1;
                        end
                    slpp_pkg::OP_LOOP:
                    begin
                        loop_taken = 1'b1;
                        if (req.items_one)
                        begin
                            step = step + 6'd1;
                        end
                        else
                        begin
                            step = slpp_pkg::BODY_BASE + cur.arg[slpp_pkg::STEP_W-1:0];
                        end
                    end
                    slpp_pkg::OP_RET:
                        step = ret;
                    default:
                        done = 1'b1;
                endcase
            end
        end
        res.step       = step;
        res.op         = slpp_pkg::slot_at(step, req.func).op;
        res.loop_taken = loop_taken;
        res.auth_ret   = ret;
    end

endmodule

/* rtl/slpp_tagger.sv */
// per-byte field tagging and layout state update
module slpp_tagger
(
    input  slpp_pkg::state_t st,
    input  logic [7:0]       data_byte,
    input  logic             eom,
    output slpp_pkg::state_t nxt,
    output slpp_pkg::res_t   res
);

    slpp_pkg::slot_t              cur;
    slpp_pkg::state_t             pre;
    slpp_pkg::res_t               res_pre;
    slpp_pkg::adv_req_t           req;
    slpp_pkg::adv_res_t           adv;
    slpp_pkg::op_t                op_after;
    logic                         adv_go;
    logic [15:0]                  bl_mid;
    logic [15:0]                  value16;
    logic                         fix_last;

    assign cur      = slpp_pkg::slot_at(st.step, st.func);
    assign value16  = {st.len_hi, data_byte};
    assign fix_last = (17'(st.bytes_left) + 17'd1) >= 17'(cur.len);

    // byte-taking part of the step, before any zero-byte steps are resolved
    always_comb
    begin
        pre               = st;
        adv_go            = 1'b0;
        bl_mid            = st.bytes_left;
        req.step          = st.step + 6'd1;
        res_pre.data      = data_byte;
        res_pre.kind      = cur.kind;
        res_pre.list      = cur.list;
        res_pre.fld_first = 1'b0;
        res_pre.fld_last  = 1'b0;
        res_pre.trunc     = 1'b0;
        res_pre.eom       = eom;
        unique case (cur.op)
            slpp_pkg::OP_FIX, slpp_pkg::OP_LEN, slpp_pkg::OP_CNT:
            begin
                res_pre.fld_first = (st.bytes_left == 16'd0);
                res_pre.fld_last  = fix_last;
                if (st.bytes_left == 16'd0)
                begin
                    pre.len_hi = data_byte;
                end
                if (cur.op == slpp_pkg::OP_FIX && cur.kind == slpp_pkg::KIND_FUNCTION)
                begin
                    pre.func = data_byte;
                end
                if (cur.op == slpp_pkg::OP_FIX && cur.kind == slpp_pkg::KIND_FLAGS)
                begin
                    pre.flags = data_byte;
                end
                if (fix_last)
                begin
                    adv_go = 1'b1;
                    if (cur.op == slpp_pkg::OP_LEN)
                    begin
                        bl_mid = value16;
                    end
                    if (cur.op == slpp_pkg::OP_CNT)
                    begin
                        pre.items = value16;
                        if (value16 == 16'd0)
                        begin
                            req.step = slpp_pkg::BODY_BASE + cur.arg[slpp_pkg::STEP_W-1:0];
                        end
                    end
                end
                else
                begin
                    pre.bytes_left = st.bytes_left + 16'd1;
                end
            end
            slpp_pkg::OP_BODY:
            begin
                res_pre.fld_first = !st.body_open;
                res_pre.fld_last  = (st.bytes_left <= 16'd1);
                pre.body_open     = 1'b1;
                bl_mid            = st.bytes_left - 16'd1;
                pre.bytes_left    = bl_mid;
                adv_go            = (bl_mid == 16'd0);
            end
            slpp_pkg::OP_UNK:
            begin
                res_pre.fld_first = !st.body_open;
                res_pre.fld_last  = eom;
                pre.body_open     = 1'b1;
            end
            default:
            begin
                // past the layout: trailing bytes
                res_pre.kind      = slpp_pkg::KIND_TRAILING;
                res_pre.list      = slpp_pkg::LIST_NONE;
                res_pre.fld_first = !st.body_open;
                res_pre.fld_last  = eom;
                pre.body_open     = 1'b1;
            end
        endcase
        req.len_zero  = (bl_mid == 16'd0);
        req.items_one = (st.items == 16'd1);
        req.flags     = pre.flags;
        req.func      = pre.func;
        req.auth_ret  = st.auth_ret;
    end

    slpp_advance u_advance
    (
        .req (req),
        .res (adv)
    );

    // merge resolved step, flag an early end, clear everything at message end
    always_comb
    begin
        nxt = pre;
        res = res_pre;
        if (adv_go)
        begin
            nxt.step      = adv.step;
            nxt.auth_ret  = adv.auth_ret;
            nxt.body_open = 1'b0;
            if (adv.loop_taken)
            begin
                nxt.items = st.items - 16'd1;
            end
            if (adv.op == slpp_pkg::OP_FIX || adv.op == slpp_pkg::OP_LEN
                || adv.op == slpp_pkg::OP_CNT)
            begin
                nxt.bytes_left = 16'd0;
            end
            else
            begin
                nxt.bytes_left = bl_mid;
            end
        end
        op_after  = adv_go ? adv.op : cur.op;
        res.trunc = eom && op_after != slpp_pkg::OP_END && op_after != slpp_pkg::OP_UNK;
        if (eom)
        begin
            nxt = slpp_pkg::STATE_RESET;
        end
    end

endmodule

/* rtl/slp_v1_message_field_parser_core.sv */
// top level of the slp v1 message field parser
//
// usage:
//  - input stream s_axis: one message byte per word in tdata, tlast on the
//    final byte of each message
//  - output stream m_axis: one word per input byte; tdata carries the byte,
//    tuser tells which header or body field it belongs to, tlast echoes the
//    input tlast and closes the message
//  - the header is tagged first, then the body layout selected by the
//    function code, with url / service type loops and auth blocks followed
//  - path: each word goes through the input register, then the result
//    register, before it shows on m_axis
//  - throughput: one word per cycle while m_axis_tready stays high, set by
//    the single tagging stage that updates the layout state once per byte
//  - reset: rst_n clears the layout state to the start of a header and
//    empties both registers; s_axis_tready is high right after reset
//  - stall: when m_axis_tready is low the result stays put; one more byte is
//    held in the input register, after that s_axis_tready drops
//  - a message ending before its layout completes gets truncated set on its
//    last word; state then returns to the header start for the next message
module slp_v1_message_field_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
    input  logic                         s_axis_tlast,  // end_of_message

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [7:0] byte_out
    // [4:0] field_kind, [7:5] list_kind, [8] field_first, [9] field_last,
    // [10] truncated
    output logic [slpp_pkg::TUSER_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast   // message_last
);

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_eom_reg;

    // layout state
    slpp_pkg::state_t state_reg;
    slpp_pkg::state_t state_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    slpp_pkg::res_t   out_reg;
    slpp_pkg::res_t   out_next;

    logic             in_fire;
    logic             calc_fire;
    logic             out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign calc_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (calc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (calc_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // tagging stage between the two registers
    slpp_tagger u_tagger
    (
        .st        (state_reg),
        .data_byte (in_byte_reg),
        .eom       (in_eom_reg),
        .nxt       (state_next),
        .res       (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= slpp_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (calc_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eom_reg  <= s_axis_tlast;
        end
        if (calc_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data;
    assign m_axis_tuser  = {out_reg.trunc, out_reg.fld_last, out_reg.fld_first,
                            out_reg.list, out_reg.kind};
    assign m_axis_tlast  = out_reg.eom;

    // the op the layout state currently rests on
    slpp_pkg::op_t rest_op;
    assign rest_op = slpp_pkg::slot_at(state_reg.step, state_reg.func).op;

    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.trunc |-> out_reg.eom)
        else $error("truncated set on a word that does not close the message");

    a_list_kind_use: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.list != slpp_pkg::LIST_NONE |->
            out_reg.kind == slpp_pkg::KIND_COUNT || out_reg.kind == slpp_pkg::KIND_LIST_LEN
            || out_reg.kind == slpp_pkg::KIND_LIST_BODY)
        else $error("list kind on a field that is not a count or list");

    a_reset_after_eom: assert property (@(posedge clk) disable iff (!rst_n)
        calc_fire && in_eom_reg |=> state_reg == slpp_pkg::STATE_RESET)
        else $error("layout state not cleared after message end");

    a_no_rest_on_jump: assert property (@(posedge clk) disable iff (!rst_n)
        !(rest_op == slpp_pkg::OP_AUTH || rest_op == slpp_pkg::OP_LOOP
          || rest_op == slpp_pkg::OP_RET))
        else $error("layout state rests on a step that takes no byte");

    a_no_empty_body: assert property (@(posedge clk) disable iff (!rst_n)
        rest_op == slpp_pkg::OP_BODY |-> state_reg.bytes_left != 16'd0)
        else $error("layout state rests on an empty body");

endmodule

/* tb/slp_v1_message_field_parser_core_tb.sv */
// self-checking testbench for the slp v1 message field parser core
module slp_v1_message_field_parser_core_tb;

    localparam int unsigned RUN_LIMIT  = 3_000_000;  // time units, far above the slowest run
    localparam int unsigned BYTE_GOAL  = 850;
    localparam int unsigned IDLE_PCT   = 14;
    localparam int unsigned QUIET_LO   = 400;        // word window with no idling on either side
    localparam int unsigned QUIET_HI   = 550;
    localparam int unsigned HOLD_AT    = 250;        // receiver holds off once here
    localparam int unsigned HOLD_LEN   = 60;
    localparam int unsigned DRAIN_AT   = 650;        // sender waits for all tags once here
    localparam int unsigned TAIL_WAIT  = 8;

    // one entry of the field layout
    typedef struct packed {
        slpp_pkg::op_t   op;
        slpp_pkg::kind_t kind;
        slpp_pkg::list_t list;
        logic [3:0]      len;
        logic [7:0]      arg;
    } lay_t;

    // one tagged byte, as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] kind;
        logic [2:0] list;
        logic       opens;
        logic       closes;
        logic       trunc;
        logic       eom;
    } tag_t;

    // a row of the directed table: stimulus plus an optional hand-typed tag
    typedef struct packed {
        bit   typed;
        tag_t want;
    } dir_row_t;

    logic                         clk     = 1'b0;
    logic                         rst_n   = 1'b0;
    logic                         s_valid = 1'b0;
    logic [7:0]                   s_data  = 8'h00;
    logic                         s_last  = 1'b0;
    logic                         m_ready = 1'b0;
    logic                         s_ready;
    logic                         m_valid;
    logic [7:0]                   m_data;
    logic [slpp_pkg::TUSER_W-1:0] m_user;
    logic                         m_last;

    // layout tables of the predictor
    lay_t hdr_tab  [8];
    lay_t auth_tab [5];
    lay_t body_tab [11][10];
    lay_t end_lay;

    // predictor state
    logic [5:0]  p_step;
    logic [15:0] p_left;
    logic [7:0]  p_func;
    logic [7:0]  p_flags;
    logic [15:0] p_items;
    logic [7:0]  p_lenhi;
    logic [5:0]  p_aret;
    logic        p_open;

    tag_t        tag_q [$];     // tags still owed by the block
    dir_row_t    dir_q [$];
    logic [7:0]  msg_q [$];     // message being built

    int unsigned n_sent  = 0;
    int unsigned n_err   = 0;
    int unsigned n_trunc = 0;
    int unsigned n_msg   = 0;
    int unsigned n_clean = 0;
    int unsigned n_cut   = 0;
    int unsigned n_noise = 0;

    always #6 clk = ~clk;

    slp_v1_message_field_parser_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // [7:0] data_byte
        .s_axis_tlast  (s_last),   // end_of_message
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // [7:0] byte_out
        // [4:0] field_kind, [7:5] list_kind, [8] field_first, [9] field_last, [10] truncated
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)    // message_last
    );

    function automatic lay_t mk_lay(input slpp_pkg::op_t op, input slpp_pkg::kind_t kind,
                                    input slpp_pkg::list_t list,
                                    input int unsigned len, input int unsigned arg);
        lay_t e;
        e.op   = op;
        e.kind = kind;
        e.list = list;
        e.len  = len[3:0];
        e.arg  = arg[7:0];
        return e;
    endfunction

    // a length prefix and its body always come as a pair
    function automatic void put_list(input int row, input int idx, input slpp_pkg::list_t l);
        body_tab[row][idx]     = mk_lay(slpp_pkg::OP_LEN, slpp_pkg::KIND_LIST_LEN, l, 2, 0);
        body_tab[row][idx + 1] = mk_lay(slpp_pkg::OP_BODY, slpp_pkg::KIND_LIST_BODY, l, 0, 0);
    endfunction

    function automatic lay_t lay_of(input logic [5:0] st);
        int s;
        int row;
        s   = int'(st);
        row = (p_func <= 8'(slpp_pkg::FN_SRV_TYPE_RPLY)) ? int'(p_func) : 0;
        if (s < int'(slpp_pkg::BODY_BASE))
            return hdr_tab[s];
        if (s >= int'(slpp_pkg::AUTH_BASE) && s < int'(slpp_pkg::AUTH_BASE) + 5)
            return auth_tab[s - int'(slpp_pkg::AUTH_BASE)];
        if (s < int'(slpp_pkg::BODY_BASE) + 10)
            return body_tab[row][s - int'(slpp_pkg::BODY_BASE)];
        return end_lay;
    endfunction

    function automatic void reset_pred();
        p_step  = '0;
        p_left  = '0;
        p_func  = '0;
        p_flags = '0;
        p_items = '0;
        p_lenhi = '0;
        p_aret  = '0;
        p_open  = 1'b0;
    endfunction

    // step forward, passing over entries that take no byte
    function automatic void walk_to(input logic [5:0] st);
        lay_t e;
        int   i;
        p_step = st;
        p_open = 1'b0;
        for (i = 0; i < 16; i++)
        begin
            e = lay_of(p_step);
            unique case (e.op)
                slpp_pkg::OP_FIX, slpp_pkg::OP_LEN, slpp_pkg::OP_CNT:
                begin
                    p_left = '0;
                    return;
                end
                slpp_pkg::OP_BODY:
                begin
                    if (p_left != 16'd0)
                        return;
                    p_step = p_step + 6'd1;
                end
                slpp_pkg::OP_AUTH:
                begin
                    if ((p_flags & e.arg) != 8'd0)
                    begin
                        p_aret = p_step + 6'd1;
                        p_step = slpp_pkg::AUTH_BASE;
                    end
                    else
                    begin
                        p_step = p_step + 6'd1;
                    end
                end
                slpp_pkg::OP_LOOP:
                begin
                    p_items = p_items - 16'd1;
                    if (p_items != 16'd0)
                        p_step = slpp_pkg::BODY_BASE + e.arg[5:0];
                    else
                        p_step = p_step + 6'd1;
                end
                slpp_pkg::OP_RET:
                    p_step = p_aret;
                default:
                    return;
            endcase
        end
    endfunction

    // tag one accepted byte and move the layout on
    function automatic tag_t predict_tag(input logic [7:0] b, input logic eom);
        lay_t          e;
        tag_t          t;
        int unsigned   n;
        logic [15:0]   v;
        slpp_pkg::op_t after;
        e        = lay_of(p_step);
        t.data   = b;
        t.kind   = e.kind;
        t.list   = e.list;
        t.opens  = 1'b0;
        t.closes = 1'b0;
        t.trunc  = 1'b0;
        t.eom    = eom;
        unique case (e.op)
            slpp_pkg::OP_FIX, slpp_pkg::OP_LEN, slpp_pkg::OP_CNT:
            begin
                n        = (e.len != 4'd0) ? 32'(e.len) : 32'd1;
                t.opens  = (p_left == 16'd0);
                t.closes = (32'(p_left) + 32'd1 >= n);
                if (t.opens)
                    p_lenhi = b;
                if (e.op == slpp_pkg::OP_FIX && e.kind == slpp_pkg::KIND_FUNCTION)
                    p_func = b;
                if (e.op == slpp_pkg::OP_FIX && e.kind == slpp_pkg::KIND_FLAGS)
                    p_flags = b;
                if (t.closes)
                begin
                    v = {p_lenhi, b};
                    if (e.op == slpp_pkg::OP_LEN)
                    begin
                        p_left = v;
                        walk_to(p_step + 6'd1);
                    end
                    else if (e.op == slpp_pkg::OP_CNT)
                    begin
                        p_items = v;
                        // a zero count skips the whole loop
                        walk_to((v != 16'd0) ? p_step + 6'd1
                                             : slpp_pkg::BODY_BASE + e.arg[5:0]);
                    end
                    else
                    begin
                        walk_to(p_step + 6'd1);
                    end
                end
                else
                begin
                    p_left = p_left + 16'd1;
                end
            end
            slpp_pkg::OP_BODY:
            begin
                t.opens  = !p_open;
                p_open   = 1'b1;
                t.closes = (p_left <= 16'd1);
                p_left   = p_left - 16'd1;
                if (p_left == 16'd0)
                    walk_to(p_step + 6'd1);
            end
            slpp_pkg::OP_UNK:
            begin
                t.opens  = !p_open;
                p_open   = 1'b1;
                t.closes = eom;
            end
            default:
            begin
                // past the layout: trailing bytes
                t.kind   = slpp_pkg::KIND_TRAILING;
                t.list   = slpp_pkg::LIST_NONE;
                t.opens  = !p_open;
                p_open   = 1'b1;
                t.closes = eom;
            end
        endcase
        after = lay_of(p_step).op;
        if (eom && after != slpp_pkg::OP_END && after != slpp_pkg::OP_UNK)
            t.trunc = 1'b1;
        if (eom)
            reset_pred();
        return t;
    endfunction

    function automatic dir_row_t mk_row(input logic [7:0] b, input int eom, input int typed,
                                        input slpp_pkg::kind_t kind,
                                        input slpp_pkg::list_t list,
                                        input int opens, input int closes,
                                        input int trunc);
        dir_row_t r;
        r.typed       = typed[0];
        r.want.data   = b;
        r.want.kind   = kind;
        r.want.list   = list;
        r.want.opens  = opens[0];
        r.want.closes = closes[0];
        r.want.trunc  = trunc[0];
        r.want.eom    = eom[0];
        return r;
    endfunction

    function automatic void add_bytes(input int n);
        repeat (n) msg_q.push_back(8'($urandom_range(255)));
    endfunction

    // mostly short strings, empty ones often, now and then one past 255 bytes
    function automatic int pick_len();
        if ($urandom_range(3) == 0)
            return 0;
        if ($urandom_range(59) == 0)
            return $urandom_range(300, 256);
        return $urandom_range(6, 1);
    endfunction

    function automatic void add_list();
        int n;
        n = pick_len();
        msg_q.push_back(n[15:8]);
        msg_q.push_back(n[7:0]);
        add_bytes(n);
    endfunction

    // timestamp and descriptor, then a length-prefixed body
    function automatic void add_auth();
        add_bytes(10);
        add_list();
    endfunction

    // well-formed message for function fn with flags fl, random content
    function automatic void build_message(input logic [7:0] fn, input logic [7:0] fl);
        int c;
        msg_q.delete();
        add_bytes(1);            // version
        msg_q.push_back(fn);
        add_bytes(2);            // length
        msg_q.push_back(fl);
        add_bytes(7);            // dialect, language, encoding, xid
        case (fn)
            8'(slpp_pkg::FN_SRV_RQST):
                repeat (2) add_list();
            8'(slpp_pkg::FN_SRV_RPLY):
            begin
                add_bytes(2);
                c = $urandom_range(3);
                msg_q.push_back(8'h00);
                msg_q.push_back(8'(c));
                repeat (c)
                begin
                    add_bytes(2);
                    add_list();
                    if ((fl & slpp_pkg::MASK_U) != 8'd0)
                        add_auth();
                end
            end
            8'(slpp_pkg::FN_SRV_REG), 8'(slpp_pkg::FN_SRV_DEREG):
            begin
                if (fn == 8'(slpp_pkg::FN_SRV_REG))
                    add_bytes(2);
                add_list();
                if ((fl & slpp_pkg::MASK_U) != 8'd0)
                    add_auth();
                add_list();
                if ((fl & slpp_pkg::MASK_A) != 8'd0)
                    add_auth();
            end
            8'(slpp_pkg::FN_SRV_ACK):
                add_bytes(2);
            8'(slpp_pkg::FN_ATTR_RQST):
                repeat (4) add_list();
            8'(slpp_pkg::FN_ATTR_RPLY):
            begin
                add_bytes(2);
                add_list();
                if ((fl & slpp_pkg::MASK_A) != 8'd0)
                    add_auth();
            end
            8'(slpp_pkg::FN_DA_ADVERT):
            begin
                add_bytes(2);
                repeat (2) add_list();
            end
            8'(slpp_pkg::FN_SRV_TYPE_RQST):
                repeat (3) add_list();
            8'(slpp_pkg::FN_SRV_TYPE_RPLY):
            begin
                add_bytes(2);
                c = $urandom_range(3);
                msg_q.push_back(8'h00);
                msg_q.push_back(8'(c));
                repeat (c) add_list();
            end
            default:
                add_bytes($urandom_range(8));
        endcase
    endfunction

    // offer one word, wait for the handshake, then record what it should become
    task automatic push_byte(input logic [7:0] b, input logic eom, input bit typed,
                             input tag_t want);
        tag_t t;
        while ((n_sent < QUIET_LO || n_sent >= QUIET_HI) && $urandom_range(99) < IDLE_PCT)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eom;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        t = predict_tag(b, eom);
        tag_q.push_back(typed ? want : t);
        n_sent++;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endfunction

    // stimulus: directed table, then random messages
    initial
    begin : stim
        int         style;
        int         k;
        int         i;
        bit         paused;
        logic [7:0] fn;
        tag_t       none;

        // layout tables
        end_lay = mk_lay(slpp_pkg::OP_END, slpp_pkg::KIND_TRAILING, slpp_pkg::LIST_NONE, 0, 0);
        foreach (body_tab[r, c])
            body_tab[r][c] = end_lay;
        hdr_tab[0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_VERSION, slpp_pkg::LIST_NONE, 1, 0);
        hdr_tab[1] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_FUNCTION, slpp_pkg::LIST_NONE, 1, 0);
        hdr_tab[2] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_LENGTH, slpp_pkg::LIST_NONE, 2, 0);
        hdr_tab[3] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_FLAGS, slpp_pkg::LIST_NONE, 1, 0);
        hdr_tab[4] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_DIALECT, slpp_pkg::LIST_NONE, 1, 0);
        hdr_tab[5] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_LANGUAGE, slpp_pkg::LIST_NONE, 2, 0);
        hdr_tab[6] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ENCODING, slpp_pkg::LIST_NONE, 2, 0);
        hdr_tab[7] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_XID, slpp_pkg::LIST_NONE, 2, 0);
        auth_tab[0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_AUTH_TIME,
                             slpp_pkg::LIST_NONE, 8, 0);
        auth_tab[1] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_AUTH_DESC,
                             slpp_pkg::LIST_NONE, 2, 0);
        auth_tab[2] = mk_lay(slpp_pkg::OP_LEN, slpp_pkg::KIND_AUTH_LEN,
                             slpp_pkg::LIST_NONE, 2, 0);
        auth_tab[3] = mk_lay(slpp_pkg::OP_BODY, slpp_pkg::KIND_AUTH_BODY,
                             slpp_pkg::LIST_NONE, 0, 0);
        auth_tab[4] = mk_lay(slpp_pkg::OP_RET, slpp_pkg::KIND_VERSION,
                             slpp_pkg::LIST_NONE, 0, 0);
        body_tab[slpp_pkg::FN_UNKNOWN][0] = mk_lay(slpp_pkg::OP_UNK, slpp_pkg::KIND_PAYLOAD,
                                                   slpp_pkg::LIST_NONE, 0, 0);
        put_list(slpp_pkg::FN_SRV_RQST, 0, slpp_pkg::LIST_PREV_RESP);
        put_list(slpp_pkg::FN_SRV_RQST, 2, slpp_pkg::LIST_PREDICATE);
        body_tab[slpp_pkg::FN_SRV_RPLY][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ERROR,
                                                    slpp_pkg::LIST_NONE, 2, 0);
        body_tab[slpp_pkg::FN_SRV_RPLY][1] = mk_lay(slpp_pkg::OP_CNT, slpp_pkg::KIND_COUNT,
                                                    slpp_pkg::LIST_URL, 2, 7);
        body_tab[slpp_pkg::FN_SRV_RPLY][2] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_LIFETIME,
                                                    slpp_pkg::LIST_NONE, 2, 0);
        put_list(slpp_pkg::FN_SRV_RPLY, 3, slpp_pkg::LIST_URL);
        body_tab[slpp_pkg::FN_SRV_RPLY][5] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                    slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_U);
        body_tab[slpp_pkg::FN_SRV_RPLY][6] = mk_lay(slpp_pkg::OP_LOOP, slpp_pkg::KIND_VERSION,
                                                    slpp_pkg::LIST_NONE, 0, 2);
        body_tab[slpp_pkg::FN_SRV_REG][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_LIFETIME,
                                                   slpp_pkg::LIST_NONE, 2, 0);
        put_list(slpp_pkg::FN_SRV_REG, 1, slpp_pkg::LIST_URL);
        body_tab[slpp_pkg::FN_SRV_REG][3] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                   slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_U);
        put_list(slpp_pkg::FN_SRV_REG, 4, slpp_pkg::LIST_ATTR);
        body_tab[slpp_pkg::FN_SRV_REG][6] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                   slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_A);
        put_list(slpp_pkg::FN_SRV_DEREG, 0, slpp_pkg::LIST_URL);
        body_tab[slpp_pkg::FN_SRV_DEREG][2] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                     slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_U);
        put_list(slpp_pkg::FN_SRV_DEREG, 3, slpp_pkg::LIST_ATTR);
        body_tab[slpp_pkg::FN_SRV_DEREG][5] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                     slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_A);
        body_tab[slpp_pkg::FN_SRV_ACK][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ERROR,
                                                   slpp_pkg::LIST_NONE, 2, 0);
        put_list(slpp_pkg::FN_ATTR_RQST, 0, slpp_pkg::LIST_PREV_RESP);
        put_list(slpp_pkg::FN_ATTR_RQST, 2, slpp_pkg::LIST_URL);
        put_list(slpp_pkg::FN_ATTR_RQST, 4, slpp_pkg::LIST_SCOPES);
        put_list(slpp_pkg::FN_ATTR_RQST, 6, slpp_pkg::LIST_ATTR);
        body_tab[slpp_pkg::FN_ATTR_RPLY][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ERROR,
                                                     slpp_pkg::LIST_NONE, 2, 0);
        put_list(slpp_pkg::FN_ATTR_RPLY, 1, slpp_pkg::LIST_ATTR);
        body_tab[slpp_pkg::FN_ATTR_RPLY][3] = mk_lay(slpp_pkg::OP_AUTH, slpp_pkg::KIND_VERSION,
                                                     slpp_pkg::LIST_NONE, 0, slpp_pkg::MASK_A);
        body_tab[slpp_pkg::FN_DA_ADVERT][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ERROR,
                                                     slpp_pkg::LIST_NONE, 2, 0);
        put_list(slpp_pkg::FN_DA_ADVERT, 1, slpp_pkg::LIST_URL);
        put_list(slpp_pkg::FN_DA_ADVERT, 3, slpp_pkg::LIST_SCOPES);
        put_list(slpp_pkg::FN_SRV_TYPE_RQST, 0, slpp_pkg::LIST_PREV_RESP);
        put_list(slpp_pkg::FN_SRV_TYPE_RQST, 2, slpp_pkg::LIST_NAMING_AUTH);
        put_list(slpp_pkg::FN_SRV_TYPE_RQST, 4, slpp_pkg::LIST_SCOPES);
        body_tab[slpp_pkg::FN_SRV_TYPE_RPLY][0] = mk_lay(slpp_pkg::OP_FIX, slpp_pkg::KIND_ERROR,
                                                         slpp_pkg::LIST_NONE, 2, 0);
        body_tab[slpp_pkg::FN_SRV_TYPE_RPLY][1] = mk_lay(slpp_pkg::OP_CNT, slpp_pkg::KIND_COUNT,
                                                         slpp_pkg::LIST_SRV_TYPES, 2, 6);
        put_list(slpp_pkg::FN_SRV_TYPE_RPLY, 2, slpp_pkg::LIST_SRV_TYPES);
        body_tab[slpp_pkg::FN_SRV_TYPE_RPLY][4] = mk_lay(slpp_pkg::OP_LOOP,
                                                         slpp_pkg::KIND_VERSION,
                                                         slpp_pkg::LIST_NONE, 0, 2);
        reset_pred();
        none   = '0;
        paused = 1'b0;

        // unknown function code at the top extreme: body is opaque payload
        dir_q.push_back(mk_row(8'h01, 0, 1, slpp_pkg::KIND_VERSION, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'hff, 0, 1, slpp_pkg::KIND_FUNCTION, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 1, slpp_pkg::KIND_LENGTH, slpp_pkg::LIST_NONE,
                               1, 0, 0));
        dir_q.push_back(mk_row(8'hff, 0, 1, slpp_pkg::KIND_LENGTH, slpp_pkg::LIST_NONE,
                               0, 1, 0));
        dir_q.push_back(mk_row(8'hff, 0, 1, slpp_pkg::KIND_FLAGS, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 1, slpp_pkg::KIND_DIALECT, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h65, 0, 1, slpp_pkg::KIND_LANGUAGE, slpp_pkg::LIST_NONE,
                               1, 0, 0));
        dir_q.push_back(mk_row(8'h6e, 0, 1, slpp_pkg::KIND_LANGUAGE, slpp_pkg::LIST_NONE,
                               0, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 0, slpp_pkg::KIND_ENCODING, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h03, 0, 0, slpp_pkg::KIND_ENCODING, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h12, 0, 0, slpp_pkg::KIND_XID, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h34, 0, 0, slpp_pkg::KIND_XID, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'ha5, 1, 1, slpp_pkg::KIND_PAYLOAD, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        // one-byte message: ends in the header
        dir_q.push_back(mk_row(8'h00, 1, 1, slpp_pkg::KIND_VERSION, slpp_pkg::LIST_NONE,
                               1, 1, 1));
        // service ack cut off inside its error code
        dir_q.push_back(mk_row(8'h01, 0, 1, slpp_pkg::KIND_VERSION, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h05, 0, 1, slpp_pkg::KIND_FUNCTION, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 1, slpp_pkg::KIND_LENGTH, slpp_pkg::LIST_NONE,
                               1, 0, 0));
        dir_q.push_back(mk_row(8'h0e, 0, 1, slpp_pkg::KIND_LENGTH, slpp_pkg::LIST_NONE,
                               0, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 1, slpp_pkg::KIND_FLAGS, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 1, slpp_pkg::KIND_DIALECT, slpp_pkg::LIST_NONE,
                               1, 1, 0));
        dir_q.push_back(mk_row(8'h65, 0, 1, slpp_pkg::KIND_LANGUAGE, slpp_pkg::LIST_NONE,
                               1, 0, 0));
        dir_q.push_back(mk_row(8'h6e, 0, 1, slpp_pkg::KIND_LANGUAGE, slpp_pkg::LIST_NONE,
                               0, 1, 0));
        dir_q.push_back(mk_row(8'h00, 0, 0, slpp_pkg::KIND_ENCODING, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h03, 0, 0, slpp_pkg::KIND_ENCODING, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'hff, 0, 0, slpp_pkg::KIND_XID, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h00, 0, 0, slpp_pkg::KIND_XID, slpp_pkg::LIST_NONE,
                               0, 0, 0));
        dir_q.push_back(mk_row(8'h00, 1, 1, slpp_pkg::KIND_ERROR, slpp_pkg::LIST_NONE,
                               1, 0, 1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_q[j])
            push_byte(dir_q[j].want.data, dir_q[j].want.eom, dir_q[j].typed, dir_q[j].want);
        n_msg += 3;

        while (n_sent < BYTE_GOAL)
        begin
            // once: let the block run dry before going on
            if (!paused && n_sent >= DRAIN_AT)
            begin
                paused = 1'b1;
                s_valid <= 1'b0;
                @(posedge clk);
                while (tag_q.size() != 0)
                    @(posedge clk);
            end
            k = $urandom_range(19);
            if (k == 0)
                fn = 8'(slpp_pkg::FN_UNKNOWN);
            else if (k == 1)
                fn = 8'($urandom_range(255, 11));
            else
                fn = 8'($urandom_range(10, 1));
            style = $urandom_range(99);
            if (style < 70)
            begin
                build_message(fn, 8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    add_bytes($urandom_range(3, 1));   // trailing bytes
                n_clean++;
            end
            else if (style < 85)
            begin
                build_message(fn, 8'($urandom_range(255)));
                k = $urandom_range(msg_q.size() - 1, 1);
                while (msg_q.size() > k)
                    void'(msg_q.pop_back());
                n_cut++;
            end
            else
            begin
                msg_q.delete();
                add_bytes($urandom_range(24, 1));
                if (msg_q.size() > 1 && $urandom_range(1) == 1)
                    msg_q[1] = 8'($urandom_range(10, 1));
                n_noise++;
            end
            n_msg++;
            for (i = 0; i < msg_q.size(); i++)
                push_byte(msg_q[i], (i == msg_q.size() - 1), 1'b0, none);
        end
        s_valid <= 1'b0;

        while (tag_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d messages (%0d well formed, %0d cut short, %0d noise), %0d words",
                 n_msg, n_clean, n_cut, n_noise, n_sent);
        $display("%0d words came back flagged truncated", n_trunc);
        if (n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off, one stretch always ready
    initial
    begin : rx_side
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && n_sent >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                m_ready <= 1'b0;
                hold_left--;
            end
            else if (n_sent >= QUIET_LO && n_sent < QUIET_HI)
            begin
                m_ready <= 1'b1;
            end
            else
            begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare every accepted word with the oldest tag owed
    always @(posedge clk)
    begin : mon
        tag_t want;
        if (rst_n && m_valid && m_ready)
        begin
            if (tag_q.size() == 0)
            begin
                $error("unexpected word: data %0h user %0h", m_data, m_user);
                n_err++;
            end
            else
            begin
                want = tag_q.pop_front();
                check_field("byte_out", want.data, m_data);
                check_field("field_kind", want.kind, m_user[4:0]);
                check_field("list_kind", want.list, m_user[7:5]);
                check_field("field_first", want.opens, m_user[8]);
                check_field("field_last", want.closes, m_user[9]);
                check_field("truncated", want.trunc, m_user[10]);
                check_field("message_last", want.eom, m_last);
                if (m_user[10])
                    n_trunc++;
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
